/* design/mtrd_pkg.sv */
// ----------------------------------------------------------------------------
// mtrd_pkg
// Shared types and constants of the ranged MT19937 draw block.
// ----------------------------------------------------------------------------
package mtrd_pkg;

	localparam int unsigned WordW = 32;
	localparam logic [31:0] InitMult  = 32'd1812433253;
	localparam logic [31:0] TwistMask = 32'h9908b0df;
	localparam logic [31:0] TemperB   = 32'h9d2c5680;
	localparam logic [31:0] TemperC   = 32'hefc60000;
	localparam logic [31:0] SeedReset = 32'd5489;

	typedef enum logic {
		OP_RESEED = 1'b0,
		OP_DRAW   = 1'b1
	} opcode_t;

	function automatic logic [31:0] temper(input logic [31:0] raw);
		logic [31:0] y;
		y = raw;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* design/mtrd_ram.sv */
// ----------------------------------------------------------------------------
// mtrd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mtrd_ram #(
	parameter int Width = 32,
	parameter int Depth = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* design/mersenne_twister_ranged_draw.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_ranged_draw
// MT19937 generator with ranged, optionally negated, offset draws.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one command beat: opcode 0 reseeds the store from the seed
//  register (no output beat), opcode 1 draws one number (one output beat on
//  m_axis). The seed register is written on the cfg channel while idle.
//  Reseed walks the 624-word store, writing one word and then forming the
//  seed for the next. A draw that finds the store used up first twists all
//  624 words, each through TW_RA, TW_RB, TW_RC (three reads) and TW_W (the
//  write), then reads, tempers and runs a bit-serial modulo, one restoring
//  step per bit. A plain draw raises m_tvalid after the read, temper, modulo
//  and offset steps; no new command beat is taken before its result is taken.
//  The serial restoring divider sets the draw time; the single RAM port
//  sets the seed and twist times.
//  After reset the block seeds itself from 5489 before it raises s_tready.
//  The result sits in an output register; while m_tready is low it holds
//  and no new command beat is taken.
// ----------------------------------------------------------------------------
module mersenne_twister_ranged_draw #(
	parameter int StateWords = 624
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: [31:0] range_limit, [32] allow_negative, [64:33] offset, rest zero
	input  logic [71:0] s_tdata,
	// tuser: [0] opcode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: [31:0] value
	output logic [31:0] m_tdata
);
	import mtrd_pkg::*;

	localparam int AW = $clog2(StateWords);
	localparam int PW = $clog2(StateWords + 1);
	localparam logic [AW-1:0] LastIdx = AW'(StateWords - 1);
	localparam logic [AW-1:0] Shift   = AW'(397);

	typedef enum logic [3:0] {
		ST_SEED_W, ST_SEED_M, ST_IDLE, ST_TW_RA, ST_TW_RB, ST_TW_RC, ST_TW_W,
		ST_RD, ST_RD_W, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  idx_q;
	logic [PW-1:0]  pos_q;
	logic [31:0]    seed_q, prev_q, a_q, b_q, lim_q, off_q, y_q, rem_q;
	logic           neg_q;
	logic [5:0]     cnt_q;
	logic [31:0]    val_q;

	logic           we;
	logic [AW-1:0]  addr;
	logic [31:0]    wdata, rdata;

	mtrd_ram #(.Width(32), .Depth(StateWords)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] i, input logic [AW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, i} + {1'b0, k};
		if (s >= (AW+1)'(StateWords)) begin
			s = s - (AW+1)'(StateWords);
		end
		return s[AW-1:0];
	endfunction

	logic [31:0] seed_prod, ymix, twisted;
	logic [32:0] trial;
	assign seed_prod = InitMult * (prev_q ^ (prev_q >> 30)) + 32'(idx_q);
	assign ymix      = {a_q[31], b_q[30:0]};
	assign twisted   = rdata ^ (ymix >> 1) ^ (ymix[0] ? TwistMask : 32'd0);
	assign trial     = {rem_q, y_q[31]} - {1'b0, lim_q};

	always_comb begin
		we = 1'b0;
		addr = idx_q;
		wdata = prev_q;
		unique case (state_q)
			ST_SEED_W: begin
				we = 1'b1;
			end
			ST_TW_RA: addr = idx_q;
			ST_TW_RB: addr = wrap_add(idx_q, AW'(1));
			ST_TW_RC: addr = wrap_add(idx_q, Shift);
			ST_TW_W: begin
				we = 1'b1;
				wdata = twisted;
			end
			ST_RD: addr = pos_q[AW-1:0];
			default: ;
		endcase
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED_W;
			idx_q   <= '0;
			pos_q   <= PW'(StateWords);
			seed_q  <= SeedReset;
			prev_q  <= SeedReset;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_SEED_W: begin
					// word idx_q written from prev_q this cycle
					if (idx_q == LastIdx) begin
						pos_q   <= PW'(StateWords);
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_SEED_M;
					end
				end
				ST_SEED_M: begin
					prev_q  <= seed_prod;
					state_q <= ST_SEED_W;
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						seed_q <= cfg_data;
					end else if (s_tvalid) begin
						if (opcode_t'(s_tuser) == OP_RESEED) begin
							prev_q  <= seed_q;
							idx_q   <= '0;
							state_q <= ST_SEED_W;
						end else begin
							lim_q <= s_tdata[31] ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
							neg_q <= s_tdata[31] | s_tdata[32];
							off_q <= s_tdata[64:33];
							idx_q <= '0;
							state_q <= (pos_q >= PW'(StateWords)) ? ST_TW_RA : ST_RD;
						end
					end
				end
				ST_TW_RA: state_q <= ST_TW_RB;
				ST_TW_RB: begin
					a_q <= rdata;
					state_q <= ST_TW_RC;
				end
				ST_TW_RC: begin
					b_q <= rdata;
					state_q <= ST_TW_W;
				end
				ST_TW_W: begin
					if (idx_q == LastIdx) begin
						pos_q   <= '0;
						state_q <= ST_RD;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_TW_RA;
					end
				end
				ST_RD: state_q <= ST_RD_W;
				ST_RD_W: begin
					pos_q <= pos_q + PW'(1);
					neg_q <= neg_q & ~rdata[3];
					y_q   <= temper(rdata);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one restoring step: shift in next dividend bit
					if (!trial[32]) begin
						rem_q <= trial[31:0];
					end else begin
						rem_q <= {rem_q[30:0], y_q[31]};
					end
					y_q   <= {y_q[30:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					val_q <= ((lim_q == 32'd0) ? 32'd0
						: (neg_q ? 32'd0 - rem_q : rem_q)) + off_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(StateWords)) else $error("draw position out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result not held under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !s_tready && !m_tvalid)
		else $error("handshake open while dividing");
`endif
endmodule
